// ----- rtl/marker_pose_heading_update_top_defines.svh -----
// ----------------------------------------------------------------------------
// Marker pose and heading update - assertion macros
// Shared property wrappers for the checker, clocked on clk.
// ----------------------------------------------------------------------------
`ifndef MARKER_POSE_HEADING_UPDATE_TOP_DEFINES_SVH
`define MARKER_POSE_HEADING_UPDATE_TOP_DEFINES_SVH

// Property checked only outside reset
`define MPHU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Property checked in and out of reset
`define MPHU_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

// ----- rtl/mphu_pkg.sv -----
// ----------------------------------------------------------------------------
// Marker pose and heading update - package
// Widths, turn constants, register indexes, control types and the CORDIC
// arctangent table.
// ----------------------------------------------------------------------------
package mphu_pkg;

  localparam int COORD_BITS   = 12;
  localparam int CORDIC_STEPS = 16;

  // Pixel fields on the stream are 12 bits; coordinates keep COORD_BITS of them
  localparam int PIX_W   = 12;
  localparam int COORD_W = (COORD_BITS < PIX_W) ? COORD_BITS : PIX_W;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int SCALE_W = 16;
  localparam int PROD_W  = DIFF_W + SCALE_W + 1;
  localparam int ACC_W   = 32;
  localparam int SUM_W   = ACC_W + 1;
  localparam int CNT_W   = 32;
  localparam int HEAD_W  = 16;

  // CORDIC datapath: vectors scaled by 2^16, angles in 2^-16 degree
  localparam int VEC_W     = 32;
  localparam int ANG_SH    = 16;
  localparam int TAB_LEN   = 24;
  localparam int TAB_IDX_W = 5;
  localparam int CORDIC_N  = (CORDIC_STEPS < TAB_LEN) ? CORDIC_STEPS : TAB_LEN;
  localparam int STEP_W    = $clog2(CORDIC_N);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(CORDIC_N - 1);

  localparam logic signed [VEC_W-1:0] QUARTER_TURN = VEC_W'(90 * 65536);
  localparam logic signed [VEC_W-1:0] HALF_TURN    = VEC_W'(180 * 65536);
  localparam logic signed [VEC_W-1:0] FULL_TURN    = VEC_W'(360 * 65536);

  // Wrapped fine angle fits below 2^25; heading keeps bits 24..9 after rounding
  localparam int FINE_W  = 25;
  localparam int HEAD_SH = 9;
  localparam logic [FINE_W-1:0] HEAD_ROUND = FINE_W'(256);
  localparam logic [HEAD_W-1:0] HEAD_WRAP  = HEAD_W'(46080);

  // Stream payload widths
  localparam int IN_TDATA_W  = 4 * PIX_W;
  localparam int OUT_TDATA_W = 2 * ACC_W + HEAD_W + CNT_W;

  // Configuration register indexes
  localparam int REG_ADDR_W = 1;
  typedef enum logic [REG_ADDR_W-1:0] {
    REG_SCALE_X = 1'b0,
    REG_SCALE_Y = 1'b1
  } mphu_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRE,
    ST_ACC,
    ST_ITER,
    ST_FIN,
    ST_EMIT
  } mphu_state_t;

  typedef struct packed {
    logic              capture;
    logic              clear_acc;
    logic              pre;
    logic              acc;
    logic              iter;
    logic [STEP_W-1:0] step;
    logic              fin;
    logic              emit;
  } mphu_cmd_t;

  typedef struct packed {
    logic out_free;
  } mphu_sts_t;

  // atan(2^-i) in 2^-16 degree
  function automatic logic signed [VEC_W-1:0] mphu_atan(input logic [TAB_IDX_W-1:0] idx);
    case (idx)
      5'd0:    return 32'sd2949120;
      5'd1:    return 32'sd1740967;
      5'd2:    return 32'sd919879;
      5'd3:    return 32'sd466945;
      5'd4:    return 32'sd234379;
      5'd5:    return 32'sd117304;
      5'd6:    return 32'sd58666;
      5'd7:    return 32'sd29335;
      5'd8:    return 32'sd14668;
      5'd9:    return 32'sd7334;
      5'd10:   return 32'sd3667;
      5'd11:   return 32'sd1833;
      5'd12:   return 32'sd917;
      5'd13:   return 32'sd458;
      5'd14:   return 32'sd229;
      5'd15:   return 32'sd115;
      5'd16:   return 32'sd57;
      5'd17:   return 32'sd29;
      5'd18:   return 32'sd14;
      5'd19:   return 32'sd7;
      5'd20:   return 32'sd4;
      5'd21:   return 32'sd2;
      5'd22:   return 32'sd1;
      default: return 32'sd0;
    endcase
  endfunction

endpackage

// ----- rtl/mphu_ctrl.sv -----
// ----------------------------------------------------------------------------
// Marker pose and heading update - controller
// Sequences one request through setup, accumulate, CORDIC steps, heading
// wrap and result hand-off.
// ----------------------------------------------------------------------------
module mphu_ctrl import mphu_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  input  logic      in_tuser,
  output logic      in_tready,
  input  mphu_sts_t sts,
  output mphu_cmd_t cmd
);

  mphu_state_t       state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        // a restart request is absorbed here and makes no result
        if (in_tvalid && !in_tuser) state_nxt = ST_PRE;
      end
      ST_PRE:  state_nxt = ST_ACC;
      ST_ACC:  state_nxt = ST_ITER;
      ST_ITER: begin
        if (step_r == STEP_LAST) state_nxt = ST_FIN;
      end
      ST_FIN:  state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    step_nxt = '0;
    if (state_r == ST_ITER && step_r != STEP_LAST) step_nxt = step_r + 1'b1;
  end

  always_comb begin
    cmd       = '0;
    cmd.step  = step_r;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready     = 1'b1;
        cmd.capture   = in_tvalid && !in_tuser;
        cmd.clear_acc = in_tvalid && in_tuser;
      end
      ST_PRE:  cmd.pre  = 1'b1;
      ST_ACC:  cmd.acc  = 1'b1;
      ST_ITER: cmd.iter = 1'b1;
      ST_FIN:  cmd.fin  = 1'b1;
      ST_EMIT: cmd.emit = sts.out_free;
      default: cmd      = '0;
    endcase
  end

endmodule

// ----- rtl/mphu_dp.sv -----
// ----------------------------------------------------------------------------
// Marker pose and heading update - datapath
// Scale registers, position accumulators with saturation, iterative CORDIC
// vectoring unit, heading rounding and the output register.
// ----------------------------------------------------------------------------
module mphu_dp import mphu_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  mphu_cmd_t              cmd,
  output mphu_sts_t              sts,
  input  logic                   cfg_we,
  input  logic [REG_ADDR_W-1:0]  cfg_addr,
  input  logic [SCALE_W-1:0]     cfg_wdata,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [SUM_W-1:0] s);
    if (s[SUM_W-1] != s[SUM_W-2]) return s[SUM_W-1] ? ACC_MIN : ACC_MAX;
    return s[ACC_W-1:0];
  endfunction

  logic [SCALE_W-1:0]        scale_x_r, scale_y_r;
  logic [COORD_W-1:0]        mx_r, my_r, ax_r, ay_r;
  logic [COORD_W-1:0]        prev_px_r, prev_py_r;
  logic signed [ACC_W-1:0]   acc_x_r, acc_y_r, acc_x_nxt, acc_y_nxt;
  logic signed [PROD_W-1:0]  prod_x_r, prod_y_r, prod_x_nxt, prod_y_nxt;
  logic signed [VEC_W-1:0]   x_r, y_r, z_r, x_nxt, y_nxt, z_nxt;
  logic                      zero_r;
  logic [FINE_W-1:0]         fine_r;
  logic                      first_done_r;
  logic [CNT_W-1:0]          emit_count_r;
  logic                      out_valid_r;
  logic [OUT_TDATA_W-1:0]    out_data_r;

  logic signed [DIFF_W-1:0]  dxa, dya, dmx, dmy;
  logic signed [SCALE_W:0]   sx_s, sy_s;
  logic signed [VEC_W-1:0]   xi, yi, xs, ys, atan_v, z_eff, fine0, fine_w;
  logic signed [SUM_W-1:0]   sum_x, sum_y;
  logic [FINE_W-1:0]         rnd;
  logic [HEAD_W-1:0]         head_raw, head;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_x_r <= '0;
      scale_y_r <= '0;
    end else if (cfg_we) begin
      case (mphu_reg_t'(cfg_addr))
        REG_SCALE_X: scale_x_r <= cfg_wdata;
        REG_SCALE_Y: scale_y_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // hold the frame's coordinates for the whole request
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mx_r <= in_tdata[0*PIX_W +: COORD_W];
      my_r <= in_tdata[1*PIX_W +: COORD_W];
      ax_r <= in_tdata[2*PIX_W +: COORD_W];
      ay_r <= in_tdata[3*PIX_W +: COORD_W];
    end
  end

  // setup: marker differences, motion products and CORDIC pre-rotation
  assign dxa  = $signed({1'b0, ax_r}) - $signed({1'b0, mx_r});
  assign dya  = $signed({1'b0, ay_r}) - $signed({1'b0, my_r});
  assign dmx  = $signed({1'b0, mx_r}) - $signed({1'b0, prev_px_r});
  assign dmy  = $signed({1'b0, my_r}) - $signed({1'b0, prev_py_r});
  assign sx_s = $signed({1'b0, scale_x_r});
  assign sy_s = $signed({1'b0, scale_y_r});
  assign prod_x_nxt = PROD_W'(dmx) * PROD_W'(sx_s);
  assign prod_y_nxt = PROD_W'(dmy) * PROD_W'(sy_s);

  // the column difference of the aux marker is the CORDIC y input
  assign xi = VEC_W'(dya) <<< ANG_SH;
  assign yi = VEC_W'(dxa) <<< ANG_SH;

  assign xs     = x_r >>> cmd.step;
  assign ys     = y_r >>> cmd.step;
  assign atan_v = mphu_atan(TAB_IDX_W'(cmd.step));

  always_comb begin
    x_nxt = x_r;
    y_nxt = y_r;
    z_nxt = z_r;
    if (cmd.pre) begin
      x_nxt = xi;
      y_nxt = yi;
      z_nxt = '0;
      // fold the left half plane in by a quarter turn
      if (xi[VEC_W-1]) begin
        if (!yi[VEC_W-1]) begin
          x_nxt = yi;
          y_nxt = -xi;
          z_nxt = QUARTER_TURN;
        end else begin
          x_nxt = -yi;
          y_nxt = xi;
          z_nxt = -QUARTER_TURN;
        end
      end
    end else if (cmd.iter) begin
      if (!y_r[VEC_W-1]) begin
        x_nxt = x_r + ys;
        y_nxt = y_r - xs;
        z_nxt = z_r + atan_v;
      end else begin
        x_nxt = x_r - ys;
        y_nxt = y_r + xs;
        z_nxt = z_r - atan_v;
      end
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
    if (cmd.pre) begin
      prod_x_r <= prod_x_nxt;
      prod_y_r <= prod_y_nxt;
      zero_r   <= (dxa == '0) && (dya == '0);
    end
  end

  // accumulate: world Y runs against the pixel row direction
  assign sum_x = SUM_W'(acc_x_r) + SUM_W'(prod_x_r);
  assign sum_y = SUM_W'(acc_y_r) - SUM_W'(prod_y_r);

  always_comb begin
    acc_x_nxt = acc_x_r;
    acc_y_nxt = acc_y_r;
    if (cmd.clear_acc) begin
      acc_x_nxt = '0;
      acc_y_nxt = '0;
    end else if (cmd.acc) begin
      // the first result after reset starts the world position at zero
      acc_x_nxt = first_done_r ? sat_acc(sum_x) : '0;
      acc_y_nxt = first_done_r ? sat_acc(sum_y) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_x_r <= '0;
      acc_y_r <= '0;
    end else begin
      acc_x_r <= acc_x_nxt;
      acc_y_r <= acc_y_nxt;
    end
  end

  // heading: half turn minus the angle, wrapped into one turn
  assign z_eff  = zero_r ? '0 : z_r;
  assign fine0  = HALF_TURN - z_eff;
  assign fine_w = fine0[VEC_W-1] ? fine0 + FULL_TURN :
                  (fine0 >= FULL_TURN) ? fine0 - FULL_TURN : fine0;

  always_ff @(posedge clk) begin
    if (cmd.fin) fine_r <= fine_w[FINE_W-1:0];
  end

  assign rnd      = fine_r + HEAD_ROUND;
  assign head_raw = rnd[FINE_W-1:HEAD_SH];
  assign head     = (!first_done_r || head_raw >= HEAD_WRAP) ? '0 : head_raw;

  // result hand-off and per-result state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      first_done_r <= 1'b0;
      emit_count_r <= '0;
      prev_px_r    <= '0;
      prev_py_r    <= '0;
    end else begin
      if (cmd.emit) begin
        out_valid_r  <= 1'b1;
        first_done_r <= 1'b1;
        emit_count_r <= emit_count_r + 1'b1;
        prev_px_r    <= mx_r;
        prev_py_r    <= my_r;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) out_data_r <= {emit_count_r, head, acc_y_r, acc_x_r};
  end

  assign sts.out_free = !out_valid_r || out_tready;
  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;

endmodule

// ----- rtl/marker_pose_heading_update_top.sv -----
// ----------------------------------------------------------------------------
// Marker pose and heading update - top level
// Integrates marker motion into a world position and finds the heading from
// the main-to-auxiliary marker vector with an iterative CORDIC.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one request per camera frame. in_tuser is the restart flag; a
//           restart zeroes the world position and makes no result.
//   out_* : one result per frame that is not a restart, held in an output
//           register until out_tready takes it.
//   cfg_* : scale_x (index 0) and scale_y (index 1), written while idle.
// Timing: a frame request yields out_tvalid after the setup, accumulate,
//   CORDIC step, heading wrap and hand-off states, and in_tready returns in
//   the same cycle, so the next frame is taken only after that hand-off. The
//   CORDIC unit does one micro-rotation per cycle.
// A pending result does not block the next request; only when a new result
//   is ready while the previous one still stalls does the block wait.
// Reset (rst_n low, synchronous) clears the scales, world position, sample
//   index and the first-result flag; the first result after reset reports
//   zero position and heading.
// ----------------------------------------------------------------------------
module marker_pose_heading_update_top import mphu_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // main_px, main_py, aux_px, aux_py
  input  logic                   in_tuser,   // restart
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // world_x, world_y, heading, sample_index
  input  logic                   cfg_we,
  input  logic [REG_ADDR_W-1:0]  cfg_addr,
  input  logic [SCALE_W-1:0]     cfg_wdata
);

  mphu_cmd_t cmd;
  mphu_sts_t sts;

  mphu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tuser  (in_tuser),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  mphu_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ----- rtl/mphu_checker.sv -----
// ----------------------------------------------------------------------------
// Marker pose and heading update - port checker
// Watches the top level's ports and is bound to it.
// ----------------------------------------------------------------------------
`include "marker_pose_heading_update_top_defines.svh"

module mphu_checker import mphu_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   in_tuser,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  // a stalled result holds
  `MPHU_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "stalled result changed")

  // a frame request keeps the block busy
  `MPHU_ASSERT(a_busy_after_frame, in_tvalid && in_tready && !in_tuser |=> !in_tready, "frame request did not occupy the block")

  // a restart makes no result
  `MPHU_ASSERT(a_restart_silent, in_tvalid && in_tready && in_tuser && !out_tvalid |=> !out_tvalid, "restart produced a result")

  // heading stays within one turn
  `MPHU_ASSERT(a_heading_range, out_tvalid |-> out_tdata[79:64] < HEAD_WRAP, "heading out of range")

  // reset leaves the block idle and empty
  `MPHU_ASSERT_RST(a_reset_idle, !rst_n |=> in_tready && !out_tvalid, "block not idle after reset")

endmodule

bind marker_pose_heading_update_top mphu_checker u_mphu_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ----- bench/marker_pose_heading_update_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Marker pose and heading update - testbench
// Streams camera frame requests into the block and checks every pose result
// against a cycle-free predictor of the position integration and the CORDIC
// heading. The run covers directed corner frames, a saturation sweep that
// ratchets the world position with scale changes, and random phases with
// bursty requests, receiver stalls and varied scales.
// ----------------------------------------------------------------------------
module marker_pose_heading_update_top_tb;
  import mphu_pkg::*;

  localparam int IDLE_LIMIT       = 2000;
  localparam int SETTLE_CYCLES    = 40;
  localparam int RANDOM_FRAMES    = 520;
  localparam int FRAMES_PER_PHASE = 40;
  localparam logic [PIX_W-1:0] PIX_MAX = '1;
  localparam longint TURN_FINE = 360 * 65536;
  // atan(2^-i) in 2^-16 degree
  localparam longint ATAN_FINE [24] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  typedef enum int {RX_OPEN, RX_LIGHT, RX_HEAVY} rx_mode_t;

  typedef struct {
    logic signed [ACC_W-1:0] world_x;
    logic signed [ACC_W-1:0] world_y;
    logic [HEAD_W-1:0]       heading;
    logic [CNT_W-1:0]        sample_index;
  } pose_t;

  class pose_scoreboard;
    logic [SCALE_W-1:0] scale_x, scale_y;
    logic [PIX_W-1:0]   prev_px, prev_py;
    longint             acc_x, acc_y;
    bit                 first_done;
    logic [CNT_W-1:0]   emit_count;
    pose_t              expected_poses[$];
    int                 errors, frames_noted, restarts_noted, poses_checked;

    function new();
      scale_x = '0;
      scale_y = '0;
      prev_px = '0;
      prev_py = '0;
      acc_x = 0;
      acc_y = 0;
      first_done = 1'b0;
      emit_count = '0;
      errors = 0;
      frames_noted = 0;
      restarts_noted = 0;
      poses_checked = 0;
    endfunction

    function void set_scale(mphu_reg_t idx, logic [SCALE_W-1:0] v);
      if (idx == REG_SCALE_X) scale_x = v;
      else scale_y = v;
    endfunction

    function int pending();
      return expected_poses.size();
    endfunction

    function longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    // 180 - atan2(ya, xa), in 1/128 degree, wrapped into [0,360)
    function logic [HEAD_W-1:0] heading_of(longint ya, longint xa);
      longint x, y, z, t, xs, ys, fine, head;
      z = 0;
      if (xa != 0 || ya != 0) begin
        x = xa * 65536;
        y = ya * 65536;
        // fold the left half plane onto the right one
        if (x < 0) begin
          t = x;
          if (y >= 0) begin
            x = y;
            y = -t;
            z = 90 * 65536;
          end else begin
            x = -y;
            y = t;
            z = -90 * 65536;
          end
        end
        for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
          xs = x >>> i;
          ys = y >>> i;
          if (y >= 0) begin
            x = x + ys;
            y = y - xs;
            z = z + ATAN_FINE[i];
          end else begin
            x = x - ys;
            y = y + xs;
            z = z - ATAN_FINE[i];
          end
        end
      end
      fine = 180 * 65536 - z;
      while (fine < 0) fine += TURN_FINE;
      while (fine >= TURN_FINE) fine -= TURN_FINE;
      head = (fine + 256) >>> 9;
      if (head >= 46080) head = 0;
      return HEAD_W'(head);
    endfunction

    function void note_frame(logic restart, logic [PIX_W-1:0] mpx, mpy, apx, apy);
      pose_t p;
      frames_noted++;
      if (restart) begin
        restarts_noted++;
        acc_x = 0;
        acc_y = 0;
        return;
      end
      acc_x = clamp32(acc_x + (longint'(mpx) - longint'(prev_px)) * longint'(scale_x));
      acc_y = clamp32(acc_y - (longint'(mpy) - longint'(prev_py)) * longint'(scale_y));
      p.heading = heading_of(longint'(apx) - longint'(mpx), longint'(apy) - longint'(mpy));
      // first pose after reset reports the origin and zero heading
      if (!first_done) begin
        acc_x = 0;
        acc_y = 0;
        p.heading = '0;
        first_done = 1'b1;
      end
      p.world_x = acc_x[ACC_W-1:0];
      p.world_y = acc_y[ACC_W-1:0];
      p.sample_index = emit_count;
      expected_poses.push_back(p);
      prev_px = mpx;
      prev_py = mpy;
      emit_count++;
    endfunction

    function void check_pose(logic [OUT_TDATA_W-1:0] d);
      pose_t want, got;
      got.world_x = d[ACC_W-1:0];
      got.world_y = d[2*ACC_W-1:ACC_W];
      got.heading = d[2*ACC_W+HEAD_W-1:2*ACC_W];
      got.sample_index = d[OUT_TDATA_W-1:2*ACC_W+HEAD_W];
      if (expected_poses.size() == 0) begin
        $error("pose result with no frame awaiting it: world_x %0d", got.world_x);
        errors++;
        return;
      end
      want = expected_poses.pop_front();
      poses_checked++;
      if (got.world_x !== want.world_x) begin
        $error("world_x: expected %0d, actual %0d", want.world_x, got.world_x);
        errors++;
      end
      if (got.world_y !== want.world_y) begin
        $error("world_y: expected %0d, actual %0d", want.world_y, got.world_y);
        errors++;
      end
      if (got.heading !== want.heading) begin
        $error("heading: expected %0d, actual %0d", want.heading, got.heading);
        errors++;
      end
      if (got.sample_index !== want.sample_index) begin
        $error("sample_index: expected %0d, actual %0d", want.sample_index, got.sample_index);
        errors++;
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;   // main_px, main_py, aux_px, aux_py
  logic                   in_tuser = 1'b0; // restart
  logic                   out_tready = 1'b0;
  logic                   cfg_we = 1'b0;
  logic [REG_ADDR_W-1:0]  cfg_addr = '0;
  logic [SCALE_W-1:0]     cfg_wdata = '0;
  wire                    in_tready;
  wire                    out_tvalid;
  wire [OUT_TDATA_W-1:0]  out_tdata;        // world_x, world_y, heading, sample_index

  pose_scoreboard   sb;
  rx_mode_t         rx_mode = RX_LIGHT;
  int               rx_left = 0;
  int               idle_cycles = 0;
  int               burst_left = 4;
  int               gap_max = 30;
  bit               tx_steady = 1'b0;
  logic [PIX_W-1:0] last_mx = '0;
  logic [PIX_W-1:0] last_my = '0;

  marker_pose_heading_update_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Receiver: always ready in open mode, else alternate ready and stall runs; stall run lengths depend on the mode
  always @(posedge clk) begin
    if (rx_mode == RX_OPEN) begin
      out_tready <= 1'b1;
      rx_left <= 0;
    end else if (rx_left == 0) begin
      out_tready <= ~out_tready;
      if (out_tready) rx_left <= (rx_mode == RX_HEAVY) ? $urandom_range(1, 60)
                                                       : $urandom_range(0, 6);
      else rx_left <= $urandom_range(0, 20);
    end else begin
      rx_left <= rx_left - 1;
    end
  end

  // Monitor and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) sb.check_pose(out_tdata);
      if (in_tvalid && in_tready)
        sb.note_frame(in_tuser, in_tdata[PIX_W-1:0], in_tdata[2*PIX_W-1:PIX_W],
                      in_tdata[3*PIX_W-1:2*PIX_W], in_tdata[4*PIX_W-1:3*PIX_W]);
      if ((out_tvalid && out_tready) || (in_tvalid && in_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $error("no request or result accepted for %0d cycles", idle_cycles);
        $display("Test completed with failures");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Offer one request and hold it until accepted; then maybe pause the sender
  task automatic send_frame(input bit restart, input logic [PIX_W-1:0] mpx, mpy, apx, apy);
    in_tvalid <= 1'b1;
    in_tuser <= restart;
    in_tdata <= {apy, apx, mpy, mpx};
    do @(posedge clk); while (!in_tready);
    if (!tx_steady) begin
      burst_left--;
      if (burst_left <= 0) begin
        burst_left = $urandom_range(1, 12);
        in_tvalid <= 1'b0;
        in_tuser <= 1'($urandom);
        in_tdata <= IN_TDATA_W'({$urandom, $urandom});
        repeat ($urandom_range(1, gap_max)) @(posedge clk);
      end
    end
  endtask

  // Drop valid, wait for every pose, then let the block go quiet
  task automatic settle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_scales(input logic [SCALE_W-1:0] sx, sy);
    cfg_we <= 1'b1;
    cfg_addr <= REG_SCALE_X;
    cfg_wdata <= sx;
    @(posedge clk);
    sb.set_scale(REG_SCALE_X, sx);
    cfg_addr <= REG_SCALE_Y;
    cfg_wdata <= sy;
    @(posedge clk);
    sb.set_scale(REG_SCALE_Y, sy);
    cfg_we <= 1'b0;
  endtask

  // Move at full scale, return at zero scale: the position ratchets into saturation
  task automatic saturate_run(input bit upward, input int rounds);
    logic [PIX_W-1:0] far_end, near_end;
    far_end = upward ? PIX_MAX : '0;
    near_end = upward ? '0 : PIX_MAX;
    repeat (rounds) begin
      settle();
      set_scales('1, '1);
      send_frame(1'b0, far_end, far_end, PIX_W'($urandom), PIX_W'($urandom));
      settle();
      set_scales('0, '0);
      send_frame(1'b0, near_end, near_end, PIX_W'($urandom), PIX_W'($urandom));
    end
  endtask

  function automatic void pick_frame(output bit restart,
                                     output logic [PIX_W-1:0] mpx, mpy, apx, apy);
    int kind;
    kind = $urandom_range(0, 15);
    restart = (kind == 0);
    mpx = PIX_W'($urandom);
    mpy = PIX_W'($urandom);
    apx = PIX_W'($urandom);
    apy = PIX_W'($urandom);
    case (kind)
      1: begin
        mpx = $urandom_range(0, 1) ? PIX_MAX : '0;
        mpy = $urandom_range(0, 1) ? PIX_MAX : '0;
        apx = $urandom_range(0, 1) ? PIX_MAX : '0;
        apy = $urandom_range(0, 1) ? PIX_MAX : '0;
      end
      2: begin
        apx = mpx;
        apy = mpy;
      end
      3: begin
        if ($urandom_range(0, 1)) apx = mpx;
        else apy = mpy;
      end
      4, 5, 6, 7, 8, 9: begin
        // tracked motion: small steps, aux marker close by
        mpx = last_mx + PIX_W'($urandom_range(0, 16)) - PIX_W'(8);
        mpy = last_my + PIX_W'($urandom_range(0, 16)) - PIX_W'(8);
        apx = mpx + PIX_W'($urandom_range(0, 128)) - PIX_W'(64);
        apy = mpy + PIX_W'($urandom_range(0, 128)) - PIX_W'(64);
      end
      default: ;
    endcase
    if (!restart) begin
      last_mx = mpx;
      last_my = mpy;
    end
  endfunction

  initial begin
    bit               rs;
    logic [PIX_W-1:0] a, b, c, d;
    int               random_sent;
    sb = new();
    random_sent = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed corners
    set_scales(16'h1234, 16'h0abc);
    send_frame(1'b0, 12'd100, 12'd200, 12'd300, 12'd50);
    send_frame(1'b0, 12'd0, 12'd0, PIX_MAX, PIX_MAX);
    send_frame(1'b0, PIX_MAX, PIX_MAX, 12'd0, 12'd0);
    send_frame(1'b0, PIX_MAX, 12'd0, 12'd0, PIX_MAX);
    send_frame(1'b0, 12'd0, PIX_MAX, PIX_MAX, 12'd0);
    send_frame(1'b0, 12'd2048, 12'd2048, 12'd2048, 12'd2048);
    send_frame(1'b0, 12'd2048, 12'd2048, 12'd2048, PIX_MAX);
    send_frame(1'b0, 12'd2048, 12'd2048, 12'd2048, 12'd0);
    send_frame(1'b0, 12'd2048, 12'd2048, PIX_MAX, 12'd2048);
    send_frame(1'b0, 12'd2048, 12'd2048, 12'd0, 12'd2048);
    send_frame(1'b0, 12'd1000, 12'd3000, 12'd1001, 12'd0);
    send_frame(1'b0, 12'd1000, 12'd3000, 12'd999, 12'd0);
    send_frame(1'b1, 12'd5, 12'd6, 12'd7, 12'd8);
    send_frame(1'b0, 12'd10, 12'd20, 12'd30, 12'd40);
    send_frame(1'b1, PIX_MAX, PIX_MAX, PIX_MAX, PIX_MAX);
    send_frame(1'b1, 12'd0, 12'd0, 12'd0, 12'd0);
    send_frame(1'b0, PIX_MAX, PIX_MAX, PIX_MAX, PIX_MAX);
    settle();
    set_scales('1, '0);
    send_frame(1'b0, 12'd0, 12'd0, 12'd1, 12'd1);
    send_frame(1'b0, PIX_MAX, PIX_MAX, 12'd3, 12'd4000);
    settle();
    set_scales('0, '1);
    send_frame(1'b0, 12'd0, 12'd0, PIX_MAX, 12'd0);
    send_frame(1'b0, PIX_MAX, PIX_MAX, 12'd0, 12'd17);

    // Saturate both ways, then clear with a restart
    saturate_run(1'b1, 10);
    saturate_run(1'b0, 20);
    settle();
    set_scales('1, '1);
    send_frame(1'b1, 12'd0, 12'd0, 12'd0, 12'd0);
    send_frame(1'b0, 12'd77, 12'd88, 12'd99, 12'd11);

    // Random phases
    while (random_sent < RANDOM_FRAMES) begin
      settle();
      case ($urandom_range(0, 4))
        0: set_scales('1, '1);
        1: set_scales('0, '0);
        2: set_scales(SCALE_W'($urandom_range(0, 255)), SCALE_W'($urandom_range(0, 255)));
        default: set_scales(SCALE_W'($urandom), SCALE_W'($urandom));
      endcase
      rx_mode <= rx_mode_t'($urandom_range(0, 2));
      tx_steady = ($urandom_range(0, 3) == 0);
      gap_max = $urandom_range(0, 1) ? 4 : 30;
      repeat (FRAMES_PER_PHASE) begin
        pick_frame(rs, a, b, c, d);
        send_frame(rs, a, b, c, d);
        random_sent++;
      end
    end
    settle();

    $display("%0d frame requests sent (%0d restarts), %0d pose results checked",
             sb.frames_noted, sb.restarts_noted, sb.poses_checked);
    $display("scales swept from zero to full scale, position driven into saturation both ways");
    if (sb.errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
